>>> rtl/core/im2c_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the int8 im2col patch gather.
// Depends on nothing; used by the interfaces, the coordinate map and the top level.
package im2c_pkg;

    // Store geometry
    localparam int MAX_IN_H   = 32;
    localparam int MAX_IN_W   = 32;
    localparam int MAX_CH     = 64;
    localparam int MAX_KERNEL = 8;
    localparam int DIL_H      = 1;
    localparam int DIL_W      = 1;

    // Item field widths
    localparam int POS_W    = 5;
    localparam int KIDX_W   = 3;
    localparam int CH_W     = 6;
    localparam int BYTE_W   = 8;

    // Configuration widths
    localparam int DIM_W    = 6;
    localparam int STEP_W   = 4;
    localparam int PAD_W    = 4;
    localparam int DIL_W_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    // Store addressing: row, column and channel are concatenated
    localparam int STORE_AW    = 2 * POS_W + CH_W;
    localparam int STORE_DEPTH = MAX_IN_H * MAX_IN_W * MAX_CH;

    // Offset that turns a signed byte into an unsigned one
    localparam logic [BYTE_W-1:0] BYTE_BIAS = 8'd128;

    // Item kinds
    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_READ  = 1'b1
    } t_kind;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_HEIGHT    = 3'd0,
        CFG_IN_WIDTH     = 3'd1,
        CFG_STRIDE_ROWS  = 3'd2,
        CFG_STRIDE_COLS  = 3'd3,
        CFG_PAD_TOP      = 3'd4,
        CFG_PAD_LEFT     = 3'd5,
        CFG_SIGNED_INPUT = 3'd6
    } t_cfg_idx;

    // Result of mapping one output coordinate onto the image
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             oob;
    } t_coord_res;

endpackage

>>> rtl/core/im2c_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one input item (image write or column read).
// Depends on im2c_pkg for field widths.
interface im2c_in_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [im2c_pkg::POS_W-1:0]      row_pos;
    logic [im2c_pkg::POS_W-1:0]      col_pos;
    logic [im2c_pkg::KIDX_W-1:0]     kernel_row;
    logic [im2c_pkg::KIDX_W-1:0]     kernel_col;
    logic [im2c_pkg::CH_W-1:0]       channel;
    logic [im2c_pkg::BYTE_W-1:0]     pixel_byte;

    modport source (output valid, kind, row_pos, col_pos, kernel_row, kernel_col,
                    channel, pixel_byte, input ready);
    modport sink   (input valid, kind, row_pos, col_pos, kernel_row, kernel_col,
                    channel, pixel_byte, output ready);
endinterface

>>> rtl/core/im2c_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one gathered column byte and its padding flag.
// Depends on im2c_pkg for field widths.
interface im2c_out_if;
    logic                        valid;
    logic                        ready;
    logic [im2c_pkg::BYTE_W-1:0] col_byte;
    logic                        padded;

    modport source (output valid, col_byte, padded, input ready);
    modport sink   (input valid, col_byte, padded, output ready);
endinterface

>>> rtl/core/im2col_int8_patch_gather.sv
`timescale 1ns / 1ps
// Int8 im2col gather: image byte store plus column-read pipeline.
// Depends on im2c_pkg, im2c_in_if, im2c_out_if and im2c_coord_map.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+------------------------------------------
//   i_in     | in  | valid/ready       | kind, row/col pos, kernel row/col, channel, byte
//   o_res    | out | valid/ready       | col_byte, padded
//   i_cfg_*  | in  | write enable only | register index, data
//
// One item is taken per cycle unless an output stall backs up to the input. A read
// item's result passes through the store read register and then the output
// register. Write items produce no result and go into the store on the cycle
// they are accepted, so a read in the very next cycle sees them. The store has no
// reset and needs no clearing pass. When the output stalls, the store read
// register holds one more result and then the input stalls too.
module im2col_int8_patch_gather (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [im2c_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [im2c_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    im2c_in_if.sink                          i_in,
    im2c_out_if.source                       o_res
);
    import im2c_pkg::*;

    // configuration registers
    logic [DIM_W-1:0]    r_in_height;
    logic [DIM_W-1:0]    r_in_width;
    logic [STEP_W-1:0]   r_stride_rows;
    logic [STEP_W-1:0]   r_stride_cols;
    logic [PAD_W-1:0]    r_pad_top;
    logic [PAD_W-1:0]    r_pad_left;
    logic                r_signed_input;

    // image store and its read register
    logic [BYTE_W-1:0]   r_store [STORE_DEPTH];
    logic [BYTE_W-1:0]   r_rdata;

    // read stage and output stage
    logic                r_s1_valid;
    logic                r_s1_pad;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_pad;
    logic [BYTE_W-1:0]   n_out_byte;

    logic                s1_adv;
    logic                in_acc;
    logic                is_read;
    logic                ch_oob;
    logic                wr_oob;
    logic                rd_pad;
    logic                store_we;
    logic                store_re;
    logic [STORE_AW-1:0] wr_addr;
    logic [STORE_AW-1:0] rd_addr;
    t_coord_res          row_res;
    t_coord_res          col_res;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_height    <= DIM_W'(MAX_IN_H);
            r_in_width     <= DIM_W'(MAX_IN_W);
            r_stride_rows  <= STEP_W'(1);
            r_stride_cols  <= STEP_W'(1);
            r_pad_top      <= '0;
            r_pad_left     <= '0;
            r_signed_input <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IN_HEIGHT:    r_in_height    <= i_cfg_data[DIM_W-1:0];
                CFG_IN_WIDTH:     r_in_width     <= i_cfg_data[DIM_W-1:0];
                CFG_STRIDE_ROWS:  r_stride_rows  <= i_cfg_data[STEP_W-1:0];
                CFG_STRIDE_COLS:  r_stride_cols  <= i_cfg_data[STEP_W-1:0];
                CFG_PAD_TOP:      r_pad_top      <= i_cfg_data[PAD_W-1:0];
                CFG_PAD_LEFT:     r_pad_left     <= i_cfg_data[PAD_W-1:0];
                CFG_SIGNED_INPUT: r_signed_input <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // coordinate mapping for rows and columns
    im2c_coord_map u_row_map (
        .i_pos     (i_in.row_pos),
        .i_kidx    (i_in.kernel_row),
        .i_stride  (r_stride_rows),
        .i_pad     (r_pad_top),
        .i_dil     (DIL_W_W'(DIL_H)),
        .i_limit   (r_in_height),
        .i_max_dim (DIM_W'(MAX_IN_H)),
        .o_res     (row_res)
    );

    im2c_coord_map u_col_map (
        .i_pos     (i_in.col_pos),
        .i_kidx    (i_in.kernel_col),
        .i_stride  (r_stride_cols),
        .i_pad     (r_pad_left),
        .i_dil     (DIL_W_W'(DIL_W)),
        .i_limit   (r_in_width),
        .i_max_dim (DIM_W'(MAX_IN_W)),
        .o_res     (col_res)
    );

    // handshake and store access decode
    always_comb begin
        s1_adv     = r_s1_valid && (!r_out_valid || o_res.ready);
        i_in.ready = !r_s1_valid || s1_adv;
        in_acc     = i_in.valid && i_in.ready;
        is_read    = (t_kind'(i_in.kind) == KIND_READ);
        ch_oob     = ({1'b0, i_in.channel} >= (CH_W + 1)'(MAX_CH));
        wr_oob     = ch_oob
                     || ({1'b0, i_in.row_pos} >= (POS_W + 1)'(MAX_IN_H))
                     || ({1'b0, i_in.col_pos} >= (POS_W + 1)'(MAX_IN_W));
        rd_pad     = ch_oob || row_res.oob || col_res.oob;
        store_we   = in_acc && !is_read && !wr_oob;
        store_re   = in_acc && is_read && !rd_pad;
        wr_addr    = {i_in.row_pos, i_in.col_pos, i_in.channel};
        rd_addr    = {row_res.pos, col_res.pos, i_in.channel};
    end

    // image store: one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[wr_addr] <= i_in.pixel_byte;
        end
        if (store_re) begin
            r_rdata <= r_store[rd_addr];
        end
    end

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= is_read;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_read) begin
            r_s1_pad <= rd_pad;
        end
    end

    // byte shaping: zero for padding, bias for signed input
    always_comb begin
        if (r_s1_pad) begin
            n_out_byte = '0;
        end else if (r_signed_input) begin
            n_out_byte = r_rdata + BYTE_BIAS;
        end else begin
            n_out_byte = r_rdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_byte <= n_out_byte;
            r_out_pad  <= r_s1_pad;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.col_byte = r_out_byte;
    assign o_res.padded   = r_out_pad;

endmodule

>>> rtl/core/im2c_coord_map.sv
`timescale 1ns / 1ps
// Maps an output position and kernel index onto an input image coordinate
// and flags positions that fall in the padding. Depends on im2c_pkg.
module im2c_coord_map (
    input  logic [im2c_pkg::POS_W-1:0]    i_pos,
    input  logic [im2c_pkg::KIDX_W-1:0]   i_kidx,
    input  logic [im2c_pkg::STEP_W-1:0]   i_stride,
    input  logic [im2c_pkg::PAD_W-1:0]    i_pad,
    input  logic [im2c_pkg::DIL_W_W-1:0]  i_dil,
    input  logic [im2c_pkg::DIM_W-1:0]    i_limit,
    input  logic [im2c_pkg::DIM_W-1:0]    i_max_dim,
    output im2c_pkg::t_coord_res          o_res
);
    import im2c_pkg::*;

    localparam int PROD_W = POS_W + STEP_W;
    localparam int KTERM_W = KIDX_W + DIL_W_W;
    localparam int SUM_W = ((PROD_W > KTERM_W) ? PROD_W : KTERM_W) + 1;
    localparam int COORD_W = SUM_W + 1;

    logic [PROD_W-1:0]         prod;
    logic [KTERM_W-1:0]        kterm;
    logic [SUM_W-1:0]          sum;
    logic signed [COORD_W-1:0] coord;
    logic [DIM_W-1:0]          limit;
    logic                      kidx_oob;

    // position * stride + kernel index * dilation - padding
    always_comb begin
        prod  = PROD_W'(i_pos) * PROD_W'(i_stride);
        kterm = KTERM_W'(i_kidx) * KTERM_W'(i_dil);
        sum   = SUM_W'(prod) + SUM_W'(kterm);
        coord = $signed({1'b0, sum}) - $signed(COORD_W'(i_pad));
    end

    // clamp the image size to the store and check bounds
    always_comb begin
        limit    = (i_limit > i_max_dim) ? i_max_dim : i_limit;
        kidx_oob = ({1'b0, i_kidx} >= (KIDX_W + 1)'(MAX_KERNEL));
        o_res.oob = kidx_oob || coord[COORD_W-1]
                    || (coord[COORD_W-2:0] >= (COORD_W - 1)'(limit));
        o_res.pos = coord[POS_W-1:0];
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for im2col_int8_patch_gather: a directed table, then random
// gather traffic checked against an in-bench model. Depends on im2c_pkg, the two
// channel interfaces and the RTL top level.
module tb;
    import im2c_pkg::*;

    localparam int STALL_LIMIT     = 3000;
    localparam int IDLE_PCT        = 38;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 4;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int PHASES          = 8;
    localparam int MAX_REPORTS     = 10;

    // One input item, with an optional hand-written expectation for reads
    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   row_pos;
        logic [POS_W-1:0]   col_pos;
        logic [KIDX_W-1:0]  kernel_row;
        logic [KIDX_W-1:0]  kernel_col;
        logic [CH_W-1:0]    channel;
        logic [BYTE_W-1:0]  pixel_byte;
        logic               fixed_exp;
        logic [BYTE_W-1:0]  exp_byte;
        logic               exp_pad;
    } t_gather_item;

    typedef struct packed {
        logic [BYTE_W-1:0] col_byte;
        logic              padded;
    } t_col_res;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_REG  = 1'b1
    } t_row_op;

    typedef struct packed {
        t_row_op                op;
        t_cfg_idx               reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        t_gather_item           item;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_data;

    im2c_in_if  in_ch ();
    im2c_out_if res_ch ();

    im2col_int8_patch_gather dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_res      (res_ch)
    );

    // Model of the image store and of the configuration registers
    logic [BYTE_W-1:0] image_mem [STORE_DEPTH];
    bit                planned   [STORE_DEPTH];
    int                img_h, img_w, step_r, step_c, pad_t, pad_l;
    bit                add_bias;

    t_gather_item feed_q[$];
    t_col_res     col_expect_q[$];
    t_stim_row    stim_rows[$];
    t_gather_item cur_item;
    bit           src_busy;
    bit           src_idle_en;
    bit           sink_idle_en;
    bit           hold_req;
    int           mismatch_cnt;
    int           stall_cnt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Map a read item onto the store; returns 1 when it lands inside the image
    function automatic bit locate_pixel(input t_gather_item it,
                                        output logic [STORE_AW-1:0] addr);
        int ir, ic, eh, ew;
        eh = (img_h > MAX_IN_H) ? MAX_IN_H : img_h;
        ew = (img_w > MAX_IN_W) ? MAX_IN_W : img_w;
        ir = int'(it.row_pos) * step_r - pad_t + int'(it.kernel_row) * DIL_H;
        ic = int'(it.col_pos) * step_c - pad_l + int'(it.kernel_col) * DIL_W;
        addr = {ir[POS_W-1:0], ic[POS_W-1:0], it.channel};
        return ir >= 0 && ir < eh && ic >= 0 && ic < ew &&
               int'(it.kernel_row) < MAX_KERNEL && int'(it.kernel_col) < MAX_KERNEL &&
               int'(it.channel) < MAX_CH;
    endfunction

    // Expected column byte for a read item
    function automatic t_col_res gather_col(input t_gather_item it);
        t_col_res            r;
        logic [STORE_AW-1:0] addr;
        r = '0;
        if (locate_pixel(it, addr)) begin
            r.col_byte = add_bias ? image_mem[addr] + BYTE_BIAS : image_mem[addr];
        end else begin
            r.padded = 1'b1;
        end
        return r;
    endfunction

    // Apply an accepted item to the model; reads queue their expectation
    task automatic absorb_item(input t_gather_item it);
        t_col_res r;
        if (it.kind == KIND_WRITE) begin
            // field widths match the store, so every write lands
            image_mem[{it.row_pos, it.col_pos, it.channel}] = it.pixel_byte;
        end else begin
            r = gather_col(it);
            if (it.fixed_exp) begin
                r.col_byte = it.exp_byte;
                r.padded   = it.exp_pad;
            end
            col_expect_q.push_back(r);
        end
    endtask

    // Input side: one item held until taken, random gaps between items
    always @(posedge i_clk) begin : feed_drive
        bit took;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            src_busy = 1'b0;
        end else begin
            took = in_ch.valid && in_ch.ready;
            if (took) begin
                absorb_item(cur_item);
                src_busy = 1'b0;
            end
            if (!src_busy) begin
                if (feed_q.size() > 0 &&
                    !(src_idle_en && $urandom_range(0, 99) < IDLE_PCT)) begin
                    cur_item = feed_q.pop_front();
                    src_busy = 1'b1;
                    in_ch.valid      <= 1'b1;
                    in_ch.kind       <= cur_item.kind;
                    in_ch.row_pos    <= cur_item.row_pos;
                    in_ch.col_pos    <= cur_item.col_pos;
                    in_ch.kernel_row <= cur_item.kernel_row;
                    in_ch.kernel_col <= cur_item.kernel_col;
                    in_ch.channel    <= cur_item.channel;
                    in_ch.pixel_byte <= cur_item.pixel_byte;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random back-pressure, plus one long hold on request
    always @(posedge i_clk) begin : sink_drive
        int hold_left;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= !(sink_idle_en && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_col_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (col_expect_q.size() == 0) begin
                mismatch_cnt = mismatch_cnt + 1;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result: col_byte %02h padded %0b",
                             res_ch.col_byte, res_ch.padded);
            end else begin
                want = col_expect_q.pop_front();
                if (res_ch.col_byte !== want.col_byte || res_ch.padded !== want.padded) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("mismatch: expected col_byte %02h padded %0b, got %02h %0b",
                                 want.col_byte, want.padded,
                                 res_ch.col_byte, res_ch.padded);
                end
            end
        end
    end

    // Watchdog: ends the run after too long without any handshake
    always @(posedge i_clk) begin : stall_watch
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // Wait until every item is taken and every result is back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (feed_q.size() != 0 || src_busy || col_expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write, mirrored into the model
    task automatic write_reg(input t_cfg_idx idx, input int val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_IN_HEIGHT:    img_h    = int'(val[DIM_W-1:0]);
            CFG_IN_WIDTH:     img_w    = int'(val[DIM_W-1:0]);
            CFG_STRIDE_ROWS:  step_r   = int'(val[STEP_W-1:0]);
            CFG_STRIDE_COLS:  step_c   = int'(val[STEP_W-1:0]);
            CFG_PAD_TOP:      pad_t    = int'(val[PAD_W-1:0]);
            CFG_PAD_LEFT:     pad_l    = int'(val[PAD_W-1:0]);
            CFG_SIGNED_INPUT: add_bias = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Table rows
    task automatic put_write(input int r, input int c, input int ch, input int px);
        t_stim_row s;
        s = '0;
        s.op = ROW_ITEM;
        s.item.kind       = KIND_WRITE;
        s.item.row_pos    = POS_W'(r);
        s.item.col_pos    = POS_W'(c);
        s.item.kernel_row = '1;     // kernel fields are don't-care on a write
        s.item.kernel_col = '1;
        s.item.channel    = CH_W'(ch);
        s.item.pixel_byte = BYTE_W'(px);
        stim_rows.push_back(s);
    endtask

    task automatic put_read(input int r, input int c, input int kr, input int kc,
                            input int ch, input bit fixed, input int eb, input bit ep);
        t_stim_row s;
        s = '0;
        s.op = ROW_ITEM;
        s.item.kind       = KIND_READ;
        s.item.row_pos    = POS_W'(r);
        s.item.col_pos    = POS_W'(c);
        s.item.kernel_row = KIDX_W'(kr);
        s.item.kernel_col = KIDX_W'(kc);
        s.item.channel    = CH_W'(ch);
        s.item.pixel_byte = 8'h5A;
        s.item.fixed_exp  = fixed;
        s.item.exp_byte   = BYTE_W'(eb);
        s.item.exp_pad    = ep;
        stim_rows.push_back(s);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input int val);
        t_stim_row s;
        s = '0;
        s.op      = ROW_REG;
        s.reg_idx = idx;
        s.reg_val = CFG_DATA_W'(val);
        stim_rows.push_back(s);
    endtask

    // Random gather traffic: mostly reads aimed at the image, some stray writes
    task automatic queue_gathers(input int n);
        t_gather_item        it, seed;
        logic [STORE_AW-1:0] addr;
        int                  roll, eh, ew, row_hi, col_hi, made;
        made = 0;
        eh = (img_h > MAX_IN_H) ? MAX_IN_H : img_h;
        ew = (img_w > MAX_IN_W) ? MAX_IN_W : img_w;
        row_hi = (step_r == 0) ? MAX_IN_H - 1 : (eh + pad_t) / step_r;
        col_hi = (step_c == 0) ? MAX_IN_W - 1 : (ew + pad_l) / step_c;
        if (row_hi > MAX_IN_H - 1) row_hi = MAX_IN_H - 1;
        if (col_hi > MAX_IN_W - 1) col_hi = MAX_IN_W - 1;
        while (made < n) begin
            roll = $urandom_range(0, 99);
            it = '0;
            it.channel    = CH_W'($urandom_range(0, MAX_CH - 1));
            it.kernel_row = KIDX_W'($urandom);
            it.kernel_col = KIDX_W'($urandom);
            it.pixel_byte = BYTE_W'($urandom);
            if (roll < 12) begin
                it.kind    = KIND_WRITE;
                it.row_pos = POS_W'($urandom);
                it.col_pos = POS_W'($urandom);
                planned[{it.row_pos, it.col_pos, it.channel}] = 1'b1;
            end else begin
                it.kind = KIND_READ;
                if (roll < 25) begin
                    it.row_pos = POS_W'($urandom);
                    it.col_pos = POS_W'($urandom);
                end else begin
                    it.row_pos = POS_W'($urandom_range(0, row_hi));
                    it.col_pos = POS_W'($urandom_range(0, col_hi));
                end
                // fill the tap first so no read lands on an unwritten byte
                if (locate_pixel(it, addr) && !planned[addr]) begin
                    seed = it;
                    seed.kind       = KIND_WRITE;
                    seed.row_pos    = addr[STORE_AW-1 -: POS_W];
                    seed.col_pos    = addr[CH_W +: POS_W];
                    seed.pixel_byte = BYTE_W'($urandom);
                    feed_q.push_back(seed);
                    planned[addr] = 1'b1;
                    made++;
                end
            end
            feed_q.push_back(it);
            made++;
        end
    endtask

    initial begin : sequencer
        int h, w, sr, sc, pt, pl, sg;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_WRITE;
        in_ch.row_pos    = '0;
        in_ch.col_pos    = '0;
        in_ch.kernel_row = '0;
        in_ch.kernel_col = '0;
        in_ch.channel    = '0;
        in_ch.pixel_byte = '0;
        res_ch.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_IN_HEIGHT;
        cfg_data         = '0;
        i_rst_n          = 1'b0;
        mismatch_cnt     = 0;
        src_idle_en      = 1'b1;
        sink_idle_en     = 1'b1;
        hold_req         = 1'b0;
        img_h = MAX_IN_H; img_w = MAX_IN_W;
        step_r = 1; step_c = 1; pad_t = 0; pad_l = 0; add_bias = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; starts from the reset configuration
        put_write(0, 0, 0, 8'h00);
        put_read(0, 0, 0, 0, 0, 1, 8'h00, 0);
        put_write(31, 31, 63, 8'hFF);
        put_read(31, 31, 0, 0, 63, 1, 8'hFF, 0);
        put_read(31, 31, 7, 7, 63, 1, 8'h00, 1);     // past the bottom right corner
        put_write(7, 7, 0, 8'hA5);
        put_read(0, 0, 7, 7, 0, 1, 8'hA5, 0);
        put_write(31, 0, 0, 8'h7F);
        put_read(24, 0, 7, 0, 0, 1, 8'h7F, 0);
        put_read(0, 31, 0, 1, 0, 1, 8'h00, 1);       // one column past the edge
        put_write(21, 10, 42, 8'h55);
        put_read(21, 10, 0, 0, 42, 1, 8'h55, 0);
        put_write(10, 21, 21, 8'hAA);
        put_read(3, 14, 7, 7, 21, 1, 8'hAA, 0);
        // read straight after a write, then overwrite
        put_write(12, 12, 12, 8'h01);
        put_read(12, 12, 0, 0, 12, 1, 8'h01, 0);
        put_write(12, 12, 12, 8'hFE);
        put_read(12, 12, 0, 0, 12, 1, 8'hFE, 0);
        // signed input: bias applied to stored bytes, never to padding
        put_reg(CFG_SIGNED_INPUT, 1);
        put_read(31, 31, 0, 0, 63, 1, 8'h7F, 0);
        put_read(0, 0, 0, 0, 0, 1, 8'h80, 0);
        put_read(31, 31, 7, 7, 63, 1, 8'h00, 1);
        // zero height pads everything; oversize height clamps to the store
        put_reg(CFG_IN_HEIGHT, 0);
        put_read(0, 0, 0, 0, 0, 1, 8'h00, 1);
        put_reg(CFG_IN_HEIGHT, 63);
        put_read(31, 31, 0, 0, 63, 1, 8'h7F, 0);
        // zero row stride, wide column stride with left padding
        put_reg(CFG_STRIDE_ROWS, 0);
        put_reg(CFG_STRIDE_COLS, 15);
        put_reg(CFG_PAD_LEFT, 15);
        put_read(31, 1, 7, 7, 0, 0, 0, 0);
        put_read(5, 0, 0, 7, 0, 0, 0, 0);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].op == ROW_REG) begin
                wait_drained();
                write_reg(stim_rows[i].reg_idx, int'(stim_rows[i].reg_val));
            end else begin
                if (stim_rows[i].item.kind == KIND_WRITE)
                    planned[{stim_rows[i].item.row_pos, stim_rows[i].item.col_pos,
                             stim_rows[i].item.channel}] = 1'b1;
                feed_q.push_back(stim_rows[i].item);
            end
        end
        wait_drained();

        // Random phases, each under its own configuration
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin h = 32; w = 32; sr = 1;  sc = 1;  pt = 0;  pl = 0;  sg = 0; end
                1: begin h = 1;  w = 1;  sr = 1;  sc = 1;  pt = 0;  pl = 0;  sg = 1; end
                2: begin h = 32; w = 32; sr = 8;  sc = 8;  pt = 15; pl = 15; sg = 0; end
                3: begin h = 63; w = 0;  sr = 0;  sc = 15; pt = 7;  pl = 3;  sg = 1; end
                4: begin h = 0;  w = 63; sr = 2;  sc = 3;  pt = 1;  pl = 2;  sg = 0; end
                5: begin h = 17; w = 5;  sr = 0;  sc = 0;  pt = 15; pl = 0;  sg = 1; end
                default: begin
                    h  = $urandom_range(1, MAX_IN_H);
                    w  = $urandom_range(1, MAX_IN_W);
                    sr = $urandom_range(1, 3);
                    sc = $urandom_range(1, 3);
                    pt = $urandom_range(0, 2);
                    pl = $urandom_range(0, 2);
                    sg = $urandom_range(0, 1);
                end
            endcase
            write_reg(CFG_IN_HEIGHT, h);
            write_reg(CFG_IN_WIDTH, w);
            write_reg(CFG_STRIDE_ROWS, sr);
            write_reg(CFG_STRIDE_COLS, sc);
            write_reg(CFG_PAD_TOP, pt);
            write_reg(CFG_PAD_LEFT, pl);
            write_reg(CFG_SIGNED_INPUT, sg);

            // phase 1 runs flat out on both sides; phase 2 starts with a long output stall
            src_idle_en  = (p != 1);
            sink_idle_en = (p != 1);
            if (p == 2)
                hold_req = 1'b1;
            queue_gathers(ITEMS_PER_PHASE);
            wait_drained();
        end

        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        if (col_expect_q.size() != 0)
            mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/im2c_pkg.sv
rtl/core/im2c_in_if.sv
rtl/core/im2c_out_if.sv
rtl/core/im2c_coord_map.sv
rtl/core/im2col_int8_patch_gather.sv
sim/tb.sv
